### rtl/graph_dfs_adjacency_matrix_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depth-first traversal block
// Shared check forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRAPH_DFS_ADJACENCY_MATRIX_DEFINES_SVH
`define GRAPH_DFS_ADJACENCY_MATRIX_DEFINES_SVH

// same-cycle implication
`define GDFS_CHECK_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GDFS_CHECK_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/gdfs_pkg.sv
// ----------------------------------------------------------------------------
// gdfs_pkg
// Types, codes and helpers for the depth-first traversal block.
// ----------------------------------------------------------------------------
package gdfs_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int RUN_LIMIT    = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
	localparam int VIDX_W       = 6;
	localparam int CNT_W        = 7;
	localparam int LABEL_W      = 8;
	localparam int ROW_W        = MAX_VERTICES;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LABEL = 2'd1,
		OP_EDGE  = 2'd2,
		OP_RUN   = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [VIDX_W-1:0]   vertex_a;
		logic [VIDX_W-1:0]   vertex_b;
		logic                edge_present;
		logic [LABEL_W-1:0]  label_value;
	} in_item_t;

	typedef struct packed {
		logic [VIDX_W-1:0]   visit_vertex;
		logic [LABEL_W-1:0]  visit_label;
		logic                last_visit;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE_WR_A,
		ST_EDGE_RD_B,
		ST_EDGE_WR_B,
		ST_RUN_INIT,
		ST_RUN_ROOT,
		ST_RUN_VISIT,
		ST_RUN_LOAD,
		ST_RUN_SCAN,
		ST_RUN_POP_RD,
		ST_RUN_POP_ROW
	} state_t;

	typedef struct packed {
		logic              found;
		logic [VIDX_W-1:0] index;
	} pick_t;

	// lowest set bit of a row bitmap
	function automatic pick_t lowest_set(input logic [ROW_W-1:0] m);
		pick_t p;
		p = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (m[i]) begin
				p.found = 1'b1;
				p.index = VIDX_W'(i);
			end
		end
		return p;
	endfunction

	// row with one presence bit replaced
	function automatic logic [ROW_W-1:0] edit_row(input logic [ROW_W-1:0] row,
			input logic [VIDX_W-1:0] col, input logic present);
		return (row & ~(ROW_W'(1) << col)) | (ROW_W'(present) << col);
	endfunction

endpackage

### rtl/gdfs_ram.sv
// ----------------------------------------------------------------------------
// gdfs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gdfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/graph_dfs_adjacency_matrix.sv
// ----------------------------------------------------------------------------
// graph_dfs_adjacency_matrix: depth-first walk over an adjacency bit matrix
// One transaction at a time. Clear and label finish as they are accepted; an edge write
// steps through ST_EDGE_WR_A, ST_EDGE_RD_B, ST_EDGE_WR_B. A run over no vertices ends in
// ST_RUN_INIT; a visit passes ST_RUN_VISIT, ST_RUN_LOAD, ST_RUN_SCAN, a return to a parent
// ST_RUN_POP_RD, ST_RUN_POP_ROW, ST_RUN_SCAN (single read port RAMs); output stalls hold ST_RUN_LOAD.
// Reset: row valid bits cleared at once (no edges), vertex_count 64, no sweep.
// ----------------------------------------------------------------------------
module graph_dfs_adjacency_matrix (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  gdfs_pkg::in_item_t           in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output gdfs_pkg::out_item_t          out_data,
	input  logic                         cfg_we,
	input  logic [gdfs_pkg::CNT_W-1:0]   cfg_wdata
);

	import gdfs_pkg::*;

	`include "graph_dfs_adjacency_matrix_defines.svh"

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    vc_q;
	in_item_t            item_q;
	logic [ROW_W-1:0]    row_valid_q;
	logic [ROW_W-1:0]    visited_q;
	logic [ROW_W-1:0]    nmask_q;
	logic [ROW_W-1:0]    cand_q;
	logic [CNT_W-1:0]    depth_q;
	logic [CNT_W-1:0]    emit_cnt_q;
	logic [CNT_W-1:0]    n_q;
	logic [VIDX_W-1:0]   cur_q;
	logic [VIDX_W-1:0]   nxt_q;
	logic                row_vld_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic [CNT_W-1:0]    n_sat;
	logic [ROW_W-1:0]    nmask_d;
	logic [ROW_W-1:0]    row_eff;
	logic [ROW_W-1:0]    row_cand;
	pick_t               root_pick;
	pick_t               scan_pick;
	logic                accept;
	logic                out_load;
	logic                run_end;
	logic                push_now;
	logic                pop_now;

	logic                adj_we, adj_re;
	logic [VIDX_W-1:0]   adj_waddr, adj_raddr;
	logic [ROW_W-1:0]    adj_wdata, adj_rdata;
	logic                lab_we, lab_re;
	logic [VIDX_W-1:0]   lab_waddr, lab_raddr;
	logic [LABEL_W-1:0]  lab_wdata, lab_rdata;
	logic                stk_we, stk_re;
	logic [VIDX_W-1:0]   stk_waddr, stk_raddr;
	logic [VIDX_W-1:0]   stk_wdata, stk_rdata;

	gdfs_ram #(.WIDTH(ROW_W), .DEPTH(MAX_VERTICES)) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.re    (adj_re),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	gdfs_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_VERTICES)) u_label_ram (
		.clk   (clk),
		.we    (lab_we),
		.waddr (lab_waddr),
		.wdata (lab_wdata),
		.re    (lab_re),
		.raddr (lab_raddr),
		.rdata (lab_rdata)
	);

	gdfs_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_VERTICES)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign n_sat     = (vc_q > CNT_W'(RUN_LIMIT)) ? CNT_W'(RUN_LIMIT) : vc_q;
	assign row_eff   = row_vld_q ? adj_rdata : '0;
	assign row_cand  = row_eff & ~visited_q & nmask_q & ~(ROW_W'(1) << cur_q);
	assign root_pick = lowest_set(~visited_q & nmask_q);
	assign scan_pick = lowest_set(cand_q);

	assign run_end  = (state_q == ST_RUN_ROOT) && !root_pick.found;
	assign push_now = (state_q == ST_RUN_VISIT);
	assign pop_now  = (state_q == ST_RUN_SCAN) && !scan_pick.found;

	always_comb begin
		for (int i = 0; i < ROW_W; i++) begin
			nmask_d[i] = (CNT_W'(i) < n_sat);
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_load  = 1'b0;
		adj_we    = 1'b0;
		adj_waddr = item_q.vertex_a;
		adj_wdata = edit_row(row_eff, item_q.vertex_b, item_q.edge_present);
		adj_re    = 1'b0;
		adj_raddr = nxt_q;
		lab_we    = 1'b0;
		lab_waddr = in_data.vertex_a;
		lab_wdata = in_data.label_value;
		lab_re    = 1'b0;
		lab_raddr = nxt_q;
		stk_we    = 1'b0;
		stk_waddr = depth_q[VIDX_W-1:0];
		stk_wdata = nxt_q;
		stk_re    = 1'b0;
		stk_raddr = VIDX_W'(depth_q - CNT_W'(2));
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_data.opcode)
						OP_LABEL: begin
							lab_we = 1'b1;
						end
						OP_EDGE: begin
							adj_re    = 1'b1;
							adj_raddr = in_data.vertex_a;
							state_d   = ST_EDGE_WR_A;
						end
						OP_RUN: begin
							state_d = ST_RUN_INIT;
						end
						default: begin
						end
					endcase
				end
			end
			ST_EDGE_WR_A: begin
				adj_we  = 1'b1;
				state_d = ST_EDGE_RD_B;
			end
			ST_EDGE_RD_B: begin
				adj_re    = 1'b1;
				adj_raddr = item_q.vertex_b;
				state_d   = ST_EDGE_WR_B;
			end
			ST_EDGE_WR_B: begin
				adj_we    = 1'b1;
				adj_waddr = item_q.vertex_b;
				adj_wdata = edit_row(row_eff, item_q.vertex_a, item_q.edge_present);
				state_d   = ST_IDLE;
			end
			ST_RUN_INIT: begin
				state_d = (n_sat == '0) ? ST_IDLE : ST_RUN_ROOT;
			end
			ST_RUN_ROOT: begin
				state_d = root_pick.found ? ST_RUN_VISIT : ST_IDLE;
			end
			ST_RUN_VISIT: begin
				stk_we  = 1'b1;
				adj_re  = 1'b1;
				lab_re  = 1'b1;
				state_d = ST_RUN_LOAD;
			end
			ST_RUN_LOAD: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_RUN_SCAN;
				end
			end
			ST_RUN_SCAN: begin
				if (scan_pick.found) begin
					state_d = ST_RUN_VISIT;
				end else if (depth_q == CNT_W'(1)) begin
					state_d = ST_RUN_ROOT;
				end else begin
					stk_re  = 1'b1;
					state_d = ST_RUN_POP_RD;
				end
			end
			ST_RUN_POP_RD: begin
				adj_re    = 1'b1;
				adj_raddr = stk_rdata;
				state_d   = ST_RUN_POP_ROW;
			end
			ST_RUN_POP_ROW: begin
				state_d = ST_RUN_SCAN;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vc_q        <= CNT_W'(64);
			row_valid_q <= '0;
			visited_q   <= '0;
			depth_q     <= '0;
			emit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				vc_q <= cfg_wdata;
			end
			if (accept && in_data.opcode == OP_CLEAR) begin
				row_valid_q <= '0;
			end
			if (state_q == ST_EDGE_WR_A) begin
				row_valid_q[item_q.vertex_a] <= 1'b1;
			end
			if (state_q == ST_EDGE_WR_B) begin
				row_valid_q[item_q.vertex_b] <= 1'b1;
			end
			if (state_q == ST_RUN_INIT) begin
				visited_q  <= '0;
				depth_q    <= '0;
				emit_cnt_q <= '0;
			end
			if (state_q == ST_RUN_VISIT) begin
				visited_q[nxt_q] <= 1'b1;
				depth_q          <= depth_q + CNT_W'(1);
				emit_cnt_q       <= emit_cnt_q + CNT_W'(1);
			end
			if (state_q == ST_RUN_SCAN && !scan_pick.found) begin
				depth_q <= depth_q - CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		if (adj_re) begin
			row_vld_q <= row_valid_q[adj_raddr];
		end
		if (state_q == ST_RUN_INIT) begin
			n_q     <= n_sat;
			nmask_q <= nmask_d;
		end
		if (state_q == ST_RUN_ROOT) begin
			nxt_q <= root_pick.index;
		end
		if (state_q == ST_RUN_SCAN) begin
			nxt_q <= scan_pick.index;
		end
		if (state_q == ST_RUN_VISIT) begin
			cur_q <= nxt_q;
		end
		if (state_q == ST_RUN_POP_RD) begin
			cur_q <= stk_rdata;
		end
		if (out_load) begin
			out_q.visit_vertex <= cur_q;
			out_q.visit_label  <= lab_rdata;
			out_q.last_visit   <= (emit_cnt_q == n_q);
			cand_q             <= row_cand;
		end
		if (state_q == ST_RUN_POP_ROW) begin
			cand_q <= row_cand;
		end
	end

	`GDFS_CHECK_IMP(a_run_covers_all, run_end, emit_cnt_q == n_q, "run ended early")
	`GDFS_CHECK_IMP(a_push_fresh, push_now, !depth_q[VIDX_W] && !visited_q[nxt_q], "bad push")
	`GDFS_CHECK_IMP(a_pop_nonempty, pop_now, depth_q != '0, "pop from an empty stack")
	`GDFS_CHECK_NXT(a_load_marks, out_load, out_valid_q && visited_q[out_q.visit_vertex], "unmarked")

endmodule

### dv/gdfs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gdfs_checker
// Watches the input, output and register ports of the traversal block, keeps
// its own copy of the graph, predicts the preorder visits of every run and
// compares each output transaction with the oldest predicted visit.
// ----------------------------------------------------------------------------
module gdfs_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  gdfs_pkg::in_item_t            in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  gdfs_pkg::out_item_t           out_data,
	input  logic                          cfg_we,
	input  logic [gdfs_pkg::CNT_W-1:0]    cfg_wdata,
	output int unsigned                   mismatches,
	output int unsigned                   pending
);

	import gdfs_pkg::*;

	logic [63:0]        edge_rows [64];
	logic [LABEL_W-1:0] vertex_tags [64];
	logic [CNT_W-1:0]   walk_count;
	out_item_t          visit_queue [$];
	out_item_t          head_visit;
	int unsigned        fail_count;

	function automatic out_item_t visit_of(input int v);
		out_item_t e;
		e.visit_vertex = VIDX_W'(v);
		e.visit_label  = vertex_tags[v];
		e.last_visit   = 1'b0;
		return e;
	endfunction

	// explicit stack of (vertex, next neighbour) pairs, restarting at each unvisited root
	task automatic predict_walk();
		logic [63:0]       seen;
		logic [VIDX_W-1:0] stk_vertex [64];
		logic [CNT_W-1:0]  stk_next [64];
		int                depth, n, v, j, top, emitted;
		n = (walk_count > 64) ? 64 : int'(walk_count);
		seen = '0;
		emitted = 0;
		for (int root = 0; root < n; root++) begin
			if (!seen[root]) begin
				seen[root] = 1'b1;
				visit_queue.push_back(visit_of(root));
				emitted++;
				stk_vertex[0] = VIDX_W'(root);
				stk_next[0] = '0;
				depth = 1;
				while (depth > 0) begin
					top = depth - 1;
					v = int'(stk_vertex[top]);
					j = int'(stk_next[top]);
					while (j < n && (j == v || !edge_rows[v][j] || seen[j]))
						j++;
					if (j < n && depth < 64) begin
						stk_next[top] = CNT_W'(j + 1);
						seen[j] = 1'b1;
						visit_queue.push_back(visit_of(j));
						emitted++;
						stk_vertex[depth] = VIDX_W'(j);
						stk_next[depth] = '0;
						depth++;
					end else begin
						depth--;
					end
				end
			end
		end
		if (emitted > 0)
			visit_queue[visit_queue.size() - 1].last_visit = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 64; r++)
				edge_rows[r] = '0;
			walk_count = CNT_W'(64);
			visit_queue.delete();
			fail_count = 0;
			pending <= 0;
			mismatches <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (visit_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected visit: vertex %0d label %0h last %0b",
							out_data.visit_vertex, out_data.visit_label,
							out_data.last_visit);
				end else begin
					head_visit = visit_queue.pop_front();
					if (out_data.visit_vertex !== head_visit.visit_vertex ||
							out_data.visit_label !== head_visit.visit_label ||
							out_data.last_visit !== head_visit.last_visit) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch exp/got: v %0d/%0d label %0h/%0h last %0b/%0b",
								head_visit.visit_vertex, out_data.visit_vertex,
								head_visit.visit_label, out_data.visit_label,
								head_visit.last_visit, out_data.last_visit);
					end
				end
			end
			if (cfg_we)
				walk_count = cfg_wdata;
			if (in_valid && in_ready) begin
				case (in_data.opcode)
					OP_CLEAR: begin
						for (int r = 0; r < 64; r++)
							edge_rows[r] = '0;
					end
					OP_LABEL: begin
						vertex_tags[in_data.vertex_a] = in_data.label_value;
					end
					OP_EDGE: begin
						edge_rows[in_data.vertex_a][in_data.vertex_b] = in_data.edge_present;
						edge_rows[in_data.vertex_b][in_data.vertex_a] = in_data.edge_present;
					end
					default: begin
						predict_walk();
					end
				endcase
			end
			pending <= visit_queue.size();
			mismatches <= fail_count;
		end
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the traversal block with label, edge, clear and run transactions:
// a directed opening, then random graphs, paths and noise over a range of
// vertex counts and idling patterns. A checker beside the block predicts and
// compares every visit; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import gdfs_pkg::*;

	localparam int SETTLE_CYCLES = 6 * 64 + 16;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_ready;
	out_item_t          out_data;
	logic               cfg_we;
	logic [CNT_W-1:0]   cfg_wdata;
	int unsigned        mismatches;
	int unsigned        pending;

	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;
	int                 items_sent = 0;
	logic [CNT_W-1:0]   live_count = CNT_W'(64);

	graph_dfs_adjacency_matrix DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	gdfs_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("tb_top failed");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic in_item_t item_of(input opcode_t op, input int a, input int b,
			input bit present, input int lbl);
		in_item_t it;
		it.opcode       = op;
		it.vertex_a     = VIDX_W'(a);
		it.vertex_b     = VIDX_W'(b);
		it.edge_present = present;
		it.label_value  = LABEL_W'(lbl);
		return it;
	endfunction

	function automatic int vertices_live();
		return (live_count > 64) ? 64 : int'(live_count);
	endfunction

	function automatic int pick_vertex();
		int n;
		n = vertices_live();
		if (n == 0 || $urandom_range(9) == 0)
			return $urandom_range(63);
		return $urandom_range(n - 1);
	endfunction

	task automatic send_item(input in_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// hold off until every predicted visit has arrived and the block is quiet
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		live_count = v;
	endtask

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
			default: begin send_idle_pct = 7; recv_stall_pct = 7; end
		endcase
	endtask

	task automatic random_phase(input int budget);
		int stop, kind, k, a, n, len, tmp, swap_at;
		int perm [64];
		stop = items_sent + budget;
		while (items_sent < stop) begin
			kind = $urandom_range(99);
			n = vertices_live();
			if (kind < 35) begin
				if ($urandom_range(1))
					send_item(item_of(OP_CLEAR, $urandom_range(63), $urandom_range(63),
						$urandom_range(1), $urandom_range(255)));
				k = $urandom_range(1, 12);
				repeat (k) begin
					a = pick_vertex();
					send_item(item_of(OP_EDGE, a,
						($urandom_range(9) == 0) ? a : pick_vertex(),
						$urandom_range(99) < 80, $urandom_range(255)));
				end
				if ($urandom_range(19) == 0)
					settle();
				send_item(item_of(OP_RUN, $urandom_range(63), $urandom_range(63),
					$urandom_range(1), $urandom_range(255)));
			end else if (kind < 55 && n >= 2) begin
				for (int i = 0; i < n; i++)
					perm[i] = i;
				for (int i = n - 1; i > 0; i--) begin
					swap_at = $urandom_range(i);
					tmp = perm[i];
					perm[i] = perm[swap_at];
					perm[swap_at] = tmp;
				end
				len = ($urandom_range(3) == 0) ? n - 1 :
					$urandom_range(1, (n - 1 < 10) ? n - 1 : 10);
				send_item(item_of(OP_CLEAR, $urandom_range(63), $urandom_range(63),
					$urandom_range(1), $urandom_range(255)));
				for (int i = 0; i < len; i++)
					send_item(item_of(OP_EDGE, perm[i], perm[i + 1], 1'b1,
						$urandom_range(255)));
				send_item(item_of(OP_RUN, $urandom_range(63), $urandom_range(63),
					$urandom_range(1), $urandom_range(255)));
			end else if (kind < 70) begin
				repeat ($urandom_range(1, 3))
					send_item(item_of(OP_LABEL, pick_vertex(), $urandom_range(63),
						$urandom_range(1), $urandom_range(255)));
				send_item(item_of(OP_RUN, $urandom_range(63), $urandom_range(63),
					$urandom_range(1), $urandom_range(255)));
			end else begin
				repeat ($urandom_range(1, 4))
					send_item(item_of(opcode_t'($urandom_range(3)), $urandom_range(63),
						$urandom_range(63), $urandom_range(1), $urandom_range(255)));
			end
		end
	endtask

	initial begin
		logic [CNT_W-1:0] counts [9];
		counts = '{CNT_W'(8), CNT_W'(127), CNT_W'(1), CNT_W'(0), CNT_W'(33),
			CNT_W'(16), CNT_W'(2), CNT_W'(64), CNT_W'(0)};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every label written before any run reads it
		for (int v = 0; v < 64; v++)
			send_item(item_of(OP_LABEL, v, $urandom_range(63), $urandom_range(1),
				$urandom_range(255)));

		send_item(item_of(OP_RUN, 0, 0, 1'b0, 0));
		send_item(item_of(OP_EDGE, 0, 63, 1'b1, 0));
		send_item(item_of(OP_EDGE, 63, 63, 1'b1, 255));
		send_item(item_of(OP_EDGE, 5, 6, 1'b1, 0));
		send_item(item_of(OP_LABEL, 63, 0, 1'b0, 255));
		send_item(item_of(OP_LABEL, 0, 63, 1'b1, 0));
		send_item(item_of(OP_RUN, 63, 63, 1'b1, 255));
		send_item(item_of(OP_EDGE, 6, 5, 1'b0, 0));
		send_item(item_of(OP_EDGE, 62, 1, 1'b1, 0));
		send_item(item_of(OP_EDGE, 1, 63, 1'b1, 0));
		send_item(item_of(OP_RUN, 0, 0, 1'b0, 0));
		send_item(item_of(OP_CLEAR, 63, 63, 1'b1, 255));
		send_item(item_of(OP_RUN, 0, 0, 1'b0, 0));
		send_item(item_of(OP_LABEL, 31, 0, 1'b0, 8'hAA));
		send_item(item_of(OP_EDGE, 63, 0, 1'b0, 0));
		send_item(item_of(OP_RUN, 0, 0, 1'b0, 0));
		settle();
		random_phase(20);

		for (int p = 0; p < 9; p++) begin
			if (p == 8)
				counts[p] = CNT_W'($urandom_range(3, 63));
			write_count(counts[p]);
			set_idling(p + 1);
			random_phase(20);
		end

		settle();
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
